// ===== src/hlc_pkg.sv =====
// Package for histogram level compaction: field widths, command codes,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package hlc_pkg;

    localparam int PIX_W  = 10;   // pixel_value and mapped_value width
    localparam int RANK_W = 10;   // stored rank width
    localparam int BITS_W = 4;    // bits_in_use register width
    localparam int APB_DW = 32;

    localparam logic [BITS_W-1:0] BITS_IN_USE_RESET = 4'd10;
    localparam logic [2:0]        ADDR_BITS_IN_USE  = 3'd0;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    typedef enum logic [2:0] {
        ST_RESET,
        ST_CLEAR,
        ST_IDLE,
        ST_BUILD,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic accept;        // input beat taken this cycle
        logic sweep_start;   // start a sweep over the presence store
        logic sweep_clear;   // sweep only clears, no table build
        logic div_start;     // start the scale division
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_ready;    // map pipeline can take a pixel
        logic sweep_done;    // last entry of the sweep processed
        logic div_done;      // scale written
    } t_dp_status;

endpackage

// ===== src/hlc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by hlc_datapath.
module hlc_div #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_dvs, n_dvs;
    logic [W:0]       w_shift;
    logic [W:0]       w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // A borrow in the top bit means the shifted remainder was below the divisor.
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/hlc_datapath.sv =====
// Datapath: presence and rank memories, build sweep, scale register and the map pipeline.
// Depends on hlc_pkg and hlc_div.
module hlc_datapath
    import hlc_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_dp_cmd,
    output t_dp_status        o_dp_status,
    input  logic [BITS_W-1:0] i_bits_in_use,
    input  logic              i_cmd,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              i_last_pixel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PIX_W-1:0]  o_mapped_value,
    output logic              o_last_out
);

    localparam int LW    = MAX_PIXEL_BITS;
    localparam int CW    = LW + 1;
    localparam int DEPTH = 1 << LW;

    // Storage
    logic              r_seen_mem [0:DEPTH-1];
    logic [RANK_W-1:0] r_rank_mem [0:DEPTH-1];

    // Depth decode
    logic [4:0]        w_bits;
    logic [CW-1:0]     w_levels;
    logic [LW-1:0]     w_level;

    // Sweep
    logic              r_sw_run;
    logic              r_sw_clear;
    logic [LW-1:0]     r_sw_addr;
    logic              r_s2_vld;
    logic              r_s2_clear;
    logic              r_s2_end;
    logic [LW-1:0]     r_s2_addr;
    logic              r_seen_rd;
    logic              w_s2_build;
    logic              w_in_range;
    logic [CW-1:0]     r_used;
    logic [CW-1:0]     w_used_nxt;
    logic [CW-1:0]     r_scale;
    logic              w_div_done;
    logic [CW-1:0]     w_quotient;

    // Map pipeline
    logic              w_map_acc;
    logic              w_out_free;
    logic              w_s1_adv;
    logic              r_s1_vld;
    logic              r_s1_last;
    logic [CW-1:0]     r_s1_scale;
    logic [RANK_W-1:0] r_rank_rd;
    logic [RANK_W+CW-1:0] w_product;
    logic              r_o_vld;
    logic [PIX_W-1:0]  r_o_data;
    logic              r_o_last;

    always_comb begin
        w_bits = {1'b0, i_bits_in_use};
        if (w_bits == 5'd0) begin
            w_bits = 5'd1;
        end else if (w_bits > 5'(LW)) begin
            w_bits = 5'(LW);
        end
        w_levels = CW'(1) << w_bits;
        w_level  = LW'(i_pixel_value) & LW'(w_levels - CW'(1));
    end

    // Presence store: the sweep reads an entry and clears it in the same cycle.
    always_ff @(posedge i_clk) begin
        if (r_sw_run) begin
            r_seen_rd             <= r_seen_mem[r_sw_addr];
            r_seen_mem[r_sw_addr] <= 1'b0;
        end else if (i_dp_cmd.accept && i_cmd == CMD_COUNT) begin
            r_seen_mem[w_level] <= 1'b1;
        end
    end

    assign w_in_range = ({1'b0, r_s2_addr} < w_levels);
    assign w_s2_build = r_s2_vld && !r_s2_clear && w_in_range;
    assign w_map_acc  = i_dp_cmd.accept && i_cmd == CMD_MAP;
    assign w_used_nxt = (w_s2_build && r_seen_rd) ? r_used + CW'(1) : r_used;

    always_ff @(posedge i_clk) begin
        if (w_s2_build) begin
            r_rank_mem[r_s2_addr] <= r_seen_rd ? RANK_W'(r_used) : '0;
        end
        if (w_map_acc) begin
            r_rank_rd <= r_rank_mem[w_level];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_run   <= 1'b0;
            r_sw_clear <= 1'b0;
            r_sw_addr  <= '0;
            r_s2_vld   <= 1'b0;
            r_s2_clear <= 1'b0;
            r_s2_end   <= 1'b0;
            r_used     <= '0;
            r_scale    <= '0;
        end else begin
            if (i_dp_cmd.sweep_start) begin
                r_sw_run   <= 1'b1;
                r_sw_clear <= i_dp_cmd.sweep_clear;
                r_sw_addr  <= '0;
            end else if (r_sw_run) begin
                r_sw_addr <= r_sw_addr + 1'b1;
                if (&r_sw_addr) begin
                    r_sw_run <= 1'b0;
                end
            end
            r_s2_vld   <= r_sw_run;
            r_s2_clear <= r_sw_clear;
            r_s2_end   <= r_sw_run && (&r_sw_addr);
            if (i_dp_cmd.sweep_start && !i_dp_cmd.sweep_clear) begin
                r_used <= '0;
            end else if (w_s2_build && r_seen_rd) begin
                r_used <= w_used_nxt;
            end
            // With no level in use the division is skipped in effect.
            if (w_div_done) begin
                r_scale <= (r_used == '0) ? w_levels : w_quotient;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr <= r_sw_addr;
    end

    // The divider starts in the sweep's final cycle, so its divisor takes in
    // the level counted in that same cycle.
    hlc_div #(
        .W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_dp_cmd.div_start),
        .i_dividend (w_levels),
        .i_divisor  (w_used_nxt),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Map pipeline: rank read, then multiply into the output register.
    assign w_out_free = !r_o_vld || i_out_ready;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign w_product  = r_rank_rd * r_s1_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_map_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_acc) begin
            r_s1_last  <= i_last_pixel;
            r_s1_scale <= r_scale;
        end
        if (w_s1_adv) begin
            r_o_data <= w_product[PIX_W-1:0];
            r_o_last <= r_s1_last;
        end
    end

    always_comb begin
        o_dp_status.pipe_ready = !r_s1_vld || w_out_free;
        o_dp_status.sweep_done = r_s2_vld && r_s2_end;
        o_dp_status.div_done   = w_div_done;
    end

    assign o_out_valid    = r_o_vld;
    assign o_mapped_value = r_o_data;
    assign o_last_out     = r_o_last;

endmodule

// ===== src/hlc_ctrl.sv =====
// Controller state machine: clearing pass, pixel acceptance, table build and scale division.
// Depends on hlc_pkg.
module hlc_ctrl
    import hlc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_cmd,
    input  logic       i_last_pixel,
    input  t_dp_status i_dp_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_dp_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RESET;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_dp_cmd   = '0;
        case (r_state)
            ST_RESET: begin
                o_dp_cmd.sweep_start = 1'b1;
                o_dp_cmd.sweep_clear = 1'b1;
                n_state = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (i_dp_status.sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready      = i_dp_status.pipe_ready;
                o_dp_cmd.accept = i_in_valid && i_dp_status.pipe_ready;
                // The last count beat starts the build in the same cycle.
                if (o_dp_cmd.accept && i_cmd == CMD_COUNT && i_last_pixel) begin
                    o_dp_cmd.sweep_start = 1'b1;
                    n_state = ST_BUILD;
                end
            end
            ST_BUILD: begin
                if (i_dp_status.sweep_done) begin
                    o_dp_cmd.div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_dp_status.div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_RESET;
            end
        endcase
    end

endmodule

// ===== src/histogram_level_compaction.sv =====
// Histogram level compaction. A map beat passes the rank read and then the output register;
// count and map beats are taken at one per cycle while the result register drains.
// The last count beat starts a build: a sweep over the presence memory, then the serial
// divider for the scale. After reset a clearing pass over the presence memory runs before
// the first beat is taken; the register port is open throughout. Reset is synchronous,
// active low.
module histogram_level_compaction
    import hlc_pkg::*;
#(
    parameter int MAX_PIXEL_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // pixel input
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              i_last_pixel,
    // mapped output
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [PIX_W-1:0]  o_mapped_value,
    output logic              o_last_out
);

    logic [BITS_W-1:0] r_bits_in_use;
    logic              w_cfg_wr;
    t_dp_cmd           w_dp_cmd;
    t_dp_status        w_dp_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_BITS_IN_USE);
    assign prdata   = (paddr == ADDR_BITS_IN_USE) ? APB_DW'(r_bits_in_use) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits_in_use <= BITS_IN_USE_RESET;
        end else if (w_cfg_wr) begin
            r_bits_in_use <= pwdata[BITS_W-1:0];
        end
    end

    hlc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_cmd        (i_cmd),
        .i_last_pixel (i_last_pixel),
        .i_dp_status  (w_dp_status),
        .o_in_ready   (o_in_ready),
        .o_dp_cmd     (w_dp_cmd)
    );

    hlc_datapath #(
        .MAX_PIXEL_BITS (MAX_PIXEL_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (w_dp_cmd),
        .o_dp_status    (w_dp_status),
        .i_bits_in_use  (r_bits_in_use),
        .i_cmd          (i_cmd),
        .i_pixel_value  (i_pixel_value),
        .i_last_pixel   (i_last_pixel),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_mapped_value (o_mapped_value),
        .o_last_out     (o_last_out)
    );

    // The last count beat closes the input until the build has finished.
    a_build_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_cmd == CMD_COUNT && i_last_pixel) |=> !o_in_ready)
        else $error("input taken in the cycle after a build started");

    a_no_input_at_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_status.sweep_done |-> !o_in_ready)
        else $error("input open while a sweep finishes");

    a_div_takes_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.div_start |=> !w_dp_status.div_done)
        else $error("divider finished straight after its start");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for histogram_level_compaction: count and map pixel beats with
// random gaps and back-pressure, each mapped pixel predicted and checked field by field.
// Depends on hlc_pkg and the histogram_level_compaction RTL.
module tb_top;
    import hlc_pkg::*;

    localparam int MAX_PIXEL_BITS   = 10;
    localparam int LEVELS_MAX       = 1 << MAX_PIXEL_BITS;
    localparam int SETTLE_CYCLES    = 1100;   // table sweep, divider and some margin
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_BEATS     = 1750;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } t_mapped;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid    = 1'b0;
    logic              o_in_ready;
    logic              i_cmd         = CMD_COUNT;
    logic [PIX_W-1:0]  i_pixel_value = '0;
    logic              i_last_pixel  = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready   = 1'b0;
    logic [PIX_W-1:0]  o_mapped_value;
    logic              o_last_out;

    // Own copy of the block state, advanced on every accepted input beat.
    bit                level_present [LEVELS_MAX];
    logic [RANK_W-1:0] level_rank [LEVELS_MAX];
    int unsigned       level_scale = 0;
    logic [BITS_W-1:0] depth_reg   = BITS_IN_USE_RESET;

    t_mapped           pending_mapped[$];
    logic [PIX_W-1:0]  channel_levels[$];
    int unsigned       mismatches = 0;
    int unsigned       beats_sent = 0;
    bit                src_gaps_en   = 1'b1;
    bit                sink_stall_en = 1'b1;
    bit                long_hold     = 1'b0;

    histogram_level_compaction #(
        .MAX_PIXEL_BITS(MAX_PIXEL_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mapped_value(o_mapped_value),
        .o_last_out    (o_last_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned level_count();
        int unsigned d;
        d = 32'(depth_reg);
        if (d < 1) d = 1;
        if (d > MAX_PIXEL_BITS) d = MAX_PIXEL_BITS;
        return 1 << d;
    endfunction

    // Present levels get their rank among present levels, absent ones get zero.
    // Entries above the current level count keep whatever an earlier build left.
    function automatic void rebuild_ranks(int unsigned levels);
        int unsigned used;
        int unsigned lv;
        used = 0;
        for (lv = 0; lv < levels; lv++) begin
            if (level_present[lv]) begin
                level_rank[lv] = used[RANK_W-1:0];
                used++;
            end else begin
                level_rank[lv] = '0;
            end
        end
        level_scale = (used == 0) ? levels : levels / used;
        foreach (level_present[i]) level_present[i] = 1'b0;
    endfunction

    function automatic void apply_pixel(logic c, logic [PIX_W-1:0] pix, logic lst);
        int unsigned levels;
        int unsigned level;
        int unsigned product;
        t_mapped     res;
        levels = level_count();
        level  = 32'(pix) & (levels - 1);
        if (c == CMD_COUNT) begin
            level_present[level] = 1'b1;
            if (lst) rebuild_ranks(levels);
        end else begin
            product   = 32'(level_rank[level]) * level_scale;
            res.value = product[PIX_W-1:0];
            res.last  = lst;
            pending_mapped.push_back(res);
        end
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        if (channel_levels.size() == 0 || $urandom_range(0, 99) < 15)
            return PIX_W'($urandom_range(0, LEVELS_MAX - 1));
        return channel_levels[$urandom_range(0, channel_levels.size() - 1)];
    endfunction

    function automatic logic [BITS_W-1:0] pick_depth();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'd15;
            2:       return 4'd1;
            3:       return 4'd10;
            default: return BITS_W'($urandom_range(2, 9));
        endcase
    endfunction

    function automatic void new_channel_levels();
        channel_levels.delete();
        repeat ($urandom_range(1, 12))
            channel_levels.push_back(PIX_W'($urandom_range(0, LEVELS_MAX - 1)));
    endfunction

    // All driving tasks are entered and left at a falling edge.
    task automatic send_beat(logic c, logic [PIX_W-1:0] pix, logic lst);
        int unsigned gap;
        gap = src_gaps_en ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= c;
        i_pixel_value <= pix;
        i_last_pixel  <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        apply_pixel(c, pix, lst);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_mapped.size() != 0) @(negedge i_clk);
    endtask

    // A count beat leaves nothing to wait for, so a build may still be running
    // when the queue is empty: allow it to finish before touching the register.
    task automatic set_depth(logic [BITS_W-1:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS_IN_USE;
        pwdata  <= ($urandom() & ~32'hF) | APB_DW'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        depth_reg = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_full_depth_extremes();
        // Reset depth of ten bits: both extreme levels, a repeated level and an unseen one.
        send_beat(CMD_COUNT, 10'd0,    1'b0);
        send_beat(CMD_COUNT, 10'd1023, 1'b0);
        send_beat(CMD_COUNT, 10'd512,  1'b0);
        send_beat(CMD_COUNT, 10'd1023, 1'b0);
        send_beat(CMD_COUNT, 10'd3,    1'b0);
        send_beat(CMD_COUNT, 10'd700,  1'b1);
        send_beat(CMD_MAP,   10'd0,    1'b0);
        send_beat(CMD_MAP,   10'd1023, 1'b0);
        send_beat(CMD_MAP,   10'd512,  1'b0);
        send_beat(CMD_MAP,   10'd3,    1'b0);
        send_beat(CMD_MAP,   10'd700,  1'b0);
        send_beat(CMD_MAP,   10'd5,    1'b0);
        send_beat(CMD_MAP,   10'd1023, 1'b1);
        wait_results();
    endtask

    task automatic test_depth_limits();
        // A depth of zero acts as one bit; upper pixel bits must be ignored.
        set_depth(4'd0);
        send_beat(CMD_COUNT, 10'h3FE, 1'b0);
        send_beat(CMD_COUNT, 10'h001, 1'b1);
        send_beat(CMD_MAP,   10'h155, 1'b0);
        send_beat(CMD_MAP,   10'h2AA, 1'b1);
        // Depth fifteen acts as ten bits; a lone level gives the full-range scale.
        set_depth(4'd15);
        send_beat(CMD_COUNT, 10'd777, 1'b1);
        send_beat(CMD_MAP,   10'd777, 1'b0);
        send_beat(CMD_MAP,   10'd778, 1'b1);
        wait_results();
    endtask

    task automatic test_depth_change_between_passes();
        set_depth(4'd3);
        send_beat(CMD_COUNT, 10'h3F5, 1'b0);
        send_beat(CMD_COUNT, 10'h002, 1'b1);
        // The map pass at six bits also reads entries left from the ten-bit build.
        set_depth(4'd6);
        send_beat(CMD_MAP, 10'd5,   1'b0);
        send_beat(CMD_MAP, 10'd2,   1'b0);
        send_beat(CMD_MAP, 10'h3F5, 1'b1);
        wait_results();
    endtask

    task automatic test_output_backpressure();
        int unsigned i;
        set_depth(4'd8);
        new_channel_levels();
        for (i = 0; i < 16; i++) send_beat(CMD_COUNT, pick_pixel(), i == 15);
        src_gaps_en = 1'b0;
        // The first map beat is only taken once the build is over; the hold starts then.
        for (i = 0; i < 40; i++) begin
            send_beat(CMD_MAP, pick_pixel(), i == 39);
            if (i == 0) long_hold = 1'b1;
        end
        wait_results();
        src_gaps_en = 1'b1;
    endtask

    task automatic noise_burst();
        int unsigned n;
        int unsigned i;
        n = $urandom_range(5, 25);
        for (i = 0; i < n; i++)
            send_beat(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, LEVELS_MAX - 1)),
                      $urandom_range(0, 15) == 0);
    endtask

    task automatic test_random_channels();
        int unsigned target;
        int unsigned n_count;
        int unsigned n_map;
        int unsigned i;
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            src_gaps_en   = $urandom_range(0, 3) != 0;
            sink_stall_en = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0) set_depth(pick_depth());
            if ($urandom_range(0, 9) == 0) begin
                noise_burst();
                continue;
            end
            new_channel_levels();
            n_count = $urandom_range(1, 40);
            for (i = 0; i < n_count; i++) send_beat(CMD_COUNT, pick_pixel(), i == n_count - 1);
            n_map = $urandom_range(1, 50);
            for (i = 0; i < n_map; i++) send_beat(CMD_MAP, pick_pixel(), i == n_map - 1);
            if ($urandom_range(0, 3) == 0) wait_results();
        end
        wait_results();
    endtask

    // Receiver pacing; a long hold is requested by the stimulus and timed here, once.
    initial begin : sink_pacing
        int unsigned stall;
        bit          hold_served;
        hold_served = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_served) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                hold_served = 1'b1;
                i_out_ready <= 1'b1;
            end else begin
                stall = sink_stall_en ? pick_gap() : 0;
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_mapped
        t_mapped want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_mapped.size() == 0) begin
                note_failure($sformatf("unexpected beat: mapped_value %0d last_out %0b",
                                       o_mapped_value, o_last_out));
            end else begin
                want = pending_mapped.pop_front();
                if (o_mapped_value !== want.value)
                    note_failure($sformatf("mapped_value: expected %0d, got %0d",
                                           want.value, o_mapped_value));
                if (o_last_out !== want.last)
                    note_failure($sformatf("last_out: expected %0b, got %0b",
                                           want.last, o_last_out));
            end
        end
    end

    initial begin : stimulus
        foreach (level_rank[i]) level_rank[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_full_depth_extremes();
        test_depth_limits();
        test_depth_change_between_passes();
        test_output_backpressure();
        test_random_channels();
        repeat (20) @(negedge i_clk);
        if (pending_mapped.size() != 0)
            note_failure($sformatf("%0d expected beats never arrived", pending_mapped.size()));
        if (mismatches == 0)
            $display("histogram_level_compaction test passed");
        else
            $display("histogram_level_compaction test failed");
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("histogram_level_compaction test failed");
        $finish;
    end

endmodule
